// ===== hdl/yaw_angle_pid_macros.svh =====
// ----------------------------------------------------------------------------
// yaw_angle_pid_macros.svh
// Assertion macros for the heading controller; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef YAW_ANGLE_PID_MACROS_SVH
`define YAW_ANGLE_PID_MACROS_SVH
`ifndef SYNTH
// ante implies cons in the same cycle
`define YAP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yaw_angle_pid: implication check failed");
// ante implies cons in the next cycle
`define YAP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yaw_angle_pid: next-cycle check failed");
`else
`define YAP_ASSERT_IMP(label, clk, rst, ante, cons)
`define YAP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/yap_pkg.sv =====
// ----------------------------------------------------------------------------
// yap_pkg
// Widths, constants, register codes and sequencer states of the heading PID.
// ----------------------------------------------------------------------------
package yap_pkg;

  localparam int ANGLE_W    = 15;
  localparam int ERR_W      = 16;
  localparam int DELTA_W    = 17;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 20;
  localparam int DRIVE_W    = 21;
  localparam int INTEG_W    = 24;
  localparam int FRAC_W     = 8;
  localparam int TOTAL_W    = 34;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 24;

  localparam int HISTORY_DEPTH_DEF = 3;

  localparam logic signed [DELTA_W-1:0] HALF_TURN = 17'sd11520;
  localparam logic signed [DELTA_W-1:0] FULL_TURN = 17'sd23040;
  localparam logic signed [DELTA_W-1:0] ERR_LIMIT = 17'sd23040;

  localparam logic [LIMIT_W-1:0]        DRIVE_LIMIT_RST = 20'hFFFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX_RST   = 24'sh7FFFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN_RST   = 24'sh800000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET_ANGLE = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_DERIV_GAIN   = 3'd3,
    REG_DRIVE_LIMIT  = 3'd4,
    REG_INTEG_MAX    = 3'd5,
    REG_INTEG_MIN    = 3'd6
  } yap_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_HIST,
    S_SUM,
    S_DSTART,
    S_DIV,
    S_MSTART,
    S_MUL,
    S_TERM,
    S_TOTAL,
    S_CLAMP
  } yap_state_t;

endpackage

// ===== hdl/yap_in_if.sv =====
// ----------------------------------------------------------------------------
// yap_in_if
// Sample channel: one measured heading per beat.
// ----------------------------------------------------------------------------
interface yap_in_if
  import yap_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] measured_angle;

  modport source (output valid, output measured_angle, input ready);
  modport sink   (input valid, input measured_angle, output ready);
endinterface

// ===== hdl/yap_out_if.sv =====
// ----------------------------------------------------------------------------
// yap_out_if
// Command channel: controller drive and wrapped heading error per beat.
// ----------------------------------------------------------------------------
interface yap_out_if
  import yap_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [ERR_W-1:0]   heading_error;

  modport source (output valid, output drive, output heading_error, input ready);
  modport sink   (input valid, input drive, input heading_error, output ready);
endinterface

// ===== hdl/yap_mul.sv =====
// ----------------------------------------------------------------------------
// yap_mul
// Bit-serial signed multiplier: one gain bit per cycle, narrow add, partial
// product shifted right each step.
// ----------------------------------------------------------------------------
module yap_mul
  import yap_pkg::*;
#(
  parameter int A_W = ERR_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [A_W-1:0]           a,
  input  logic signed [GAIN_W-1:0]        b,
  output logic                            done,
  output logic signed [A_W+GAIN_W-1:0]    product
);

  localparam int CNT_W = $clog2(GAIN_W);

  logic signed [A_W-1:0]  mcand;
  logic [GAIN_W-1:0]      mplier;
  logic signed [A_W:0]    hi;
  logic [GAIN_W-1:0]      lo;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   last;
  logic signed [A_W+1:0]  addend;
  logic signed [A_W+1:0]  partial;

  assign last = (cnt == CNT_W'(GAIN_W - 1));

  // sign bit of the gain carries negative weight
  always_comb begin
    addend = '0;
    if (mplier[0]) begin
      if (last) begin
        addend = -{{2{mcand[A_W-1]}}, mcand};
      end else begin
        addend = {{2{mcand[A_W-1]}}, mcand};
      end
    end
    partial = {hi[A_W], hi} + addend;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= a;
      mplier <= b;
      hi     <= '0;
      lo     <= '0;
    end else if (busy) begin
      hi     <= partial[A_W+1:1];
      lo     <= {partial[0], lo[GAIN_W-1:1]};
      mplier <= {1'b0, mplier[GAIN_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign product = {hi[A_W-1:0], lo};

endmodule

// ===== hdl/yap_div.sv =====
// ----------------------------------------------------------------------------
// yap_div
// Restoring divider, one quotient bit per cycle; signed dividend by a small
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module yap_div
  import yap_pkg::*;
#(
  parameter int N_W = DELTA_W + 2,
  parameter int D_W = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [N_W-1:0] dividend,
  input  logic [D_W-1:0]        divisor,
  output logic                  done,
  output logic signed [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W);

  logic [N_W-1:0]   mag;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsor;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             last;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             fits;

  assign last    = (cnt == CNT_W'(N_W - 1));
  assign shifted = {rem, mag[N_W-1]};
  assign fits    = (shifted >= {1'b0, dsor});
  assign trial   = shifted - {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= dividend[N_W-1] ? N_W'(-dividend) : N_W'(dividend);
      neg  <= dividend[N_W-1];
      dsor <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem <= fits ? trial[D_W-1:0] : shifted[D_W-1:0];
      mag <= {mag[N_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== hdl/yaw_angle_pid.sv =====
// ----------------------------------------------------------------------------
// yaw_angle_pid
// Heading PID controller with +/-180 degree wrap, serial arithmetic.
//
//   channel   dir  beat contents                     handshake
//   sample    in   measured_angle (s15)              valid/ready
//   command   out  drive (s21), heading_error (s16)  valid/ready
//   wr_*      in   wr_index (3), wr_data (24)        wr_en, no wait
//
// One beat at a time: a new sample is accepted only in idle, after the last
// beat has been loaded. The time per beat grows with n = held differences
// (1..HISTORY_DEPTH), SUM_W = 17 + clog2(depth): mostly the serial divider
// (SUM_W steps) and the three bit-serial gain multipliers (16 steps).
// Synchronous reset clears state; config is taken any cycle.
// A stalled command beat holds in the output register; the next sample is
// still accepted and computed, waiting only at the final load.
// ----------------------------------------------------------------------------
module yaw_angle_pid
  import yap_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  yap_in_if.sink                sample,
  yap_out_if.source             command,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data
);

`include "yaw_angle_pid_macros.svh"

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = DELTA_W + $clog2(HISTORY_DEPTH);

  // configuration
  logic signed [ANGLE_W-1:0] target_angle;
  logic signed [GAIN_W-1:0]  prop_gain;
  logic signed [GAIN_W-1:0]  integ_gain;
  logic signed [GAIN_W-1:0]  deriv_gain;
  logic [LIMIT_W-1:0]        drive_limit;
  logic signed [INTEG_W-1:0] integ_max;
  logic signed [INTEG_W-1:0] integ_min;

  yap_state_t state, state_next;

  logic signed [ANGLE_W-1:0] angle;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   err_next;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [INTEG_W-1:0] error_sum;
  logic signed [DELTA_W-1:0] hist [HISTORY_DEPTH];
  logic [CNT_W-1:0]          hist_count;
  logic                      hist_full;
  logic signed [DELTA_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum_acc;
  logic [IDX_W-1:0]          sum_idx;
  logic                      sum_last;
  logic signed [SUM_W-1:0]   mean;

  logic signed [DELTA_W-1:0] err_raw;
  logic signed [DELTA_W-1:0] angle_wrap;
  logic signed [DELTA_W-1:0] err_wrap;
  logic signed [DELTA_W-1:0] err_sel;
  logic signed [INTEG_W:0]   integ_acc;

  logic                      div_start;
  logic                      div_done;
  logic signed [SUM_W-1:0]   quotient;
  logic                      mul_start;
  logic                      p_done;
  logic                      i_done;
  logic                      d_done;
  logic signed [ERR_W+GAIN_W-1:0]   p_prod;
  logic signed [INTEG_W+GAIN_W-1:0] i_prod;
  logic signed [SUM_W+GAIN_W-1:0]   d_prod;

  logic signed [ERR_W+GAIN_W-FRAC_W-1:0] p_sh;
  logic signed [DRIVE_W-1:0] lim_pos;
  logic signed [DRIVE_W-1:0] lim_neg;
  logic signed [DRIVE_W-1:0] p_term;
  logic signed [TOTAL_W-1:0] id_sum;
  logic signed [TOTAL_W-1:0] total;

  logic                      out_load;
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] drive_q;
  logic signed [ERR_W-1:0]   heading_error_q;

  // -------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= '0;
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      drive_limit  <= DRIVE_LIMIT_RST;
      integ_max    <= INTEG_MAX_RST;
      integ_min    <= INTEG_MIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TARGET_ANGLE: target_angle <= wr_data[ANGLE_W-1:0];
        REG_PROP_GAIN:    prop_gain    <= wr_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain   <= wr_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain   <= wr_data[GAIN_W-1:0];
        REG_DRIVE_LIMIT:  drive_limit  <= wr_data[LIMIT_W-1:0];
        REG_INTEG_MAX:    integ_max    <= wr_data[INTEG_W-1:0];
        REG_INTEG_MIN:    integ_min    <= wr_data[INTEG_W-1:0];
        default:          ;
      endcase
    end
  end

  // ----------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    div_start    = 1'b0;
    mul_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = S_ERR;
        end
      end
      S_ERR:    state_next = S_HIST;
      S_HIST:   state_next = S_SUM;
      S_SUM: begin
        if (sum_last) begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MSTART;
        end
      end
      S_MSTART: begin
        mul_start  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (p_done) begin
          state_next = S_TERM;
        end
      end
      S_TERM:   state_next = S_TOTAL;
      S_TOTAL:  state_next = S_CLAMP;
      S_CLAMP: begin
        if (!out_valid || command.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // ----------------------------------------------------- error and wrap
  always_comb begin
    err_raw    = DELTA_W'(target_angle) - DELTA_W'(angle);
    angle_wrap = (angle > 0) ? DELTA_W'(angle) - FULL_TURN : DELTA_W'(angle) + FULL_TURN;
    err_wrap   = DELTA_W'(target_angle) - angle_wrap;
    err_sel    = (err_raw > HALF_TURN || err_raw < -HALF_TURN) ? err_wrap : err_raw;
    if (err_sel > ERR_LIMIT) begin
      err_next = ERR_W'(ERR_LIMIT);
    end else if (err_sel < -ERR_LIMIT) begin
      err_next = ERR_W'(-ERR_LIMIT);
    end else begin
      err_next = ERR_W'(err_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      angle <= sample.measured_angle;
    end
    if (state == S_ERR) begin
      err <= err_next;
    end
  end

  // ------------------------------------------------ history, integrator
  assign delta     = DELTA_W'(err) - DELTA_W'(prev_error);
  assign hist_full = (hist_count == CNT_W'(HISTORY_DEPTH));
  assign integ_acc = (INTEG_W+1)'(error_sum) + (INTEG_W+1)'(err);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count <= '0;
      prev_error <= '0;
      error_sum  <= '0;
    end else if (wr_en && wr_index == REG_TARGET_ANGLE) begin
      hist_count <= '0;
      prev_error <= '0;
    end else if (state == S_HIST) begin
      prev_error <= err;
      if (!hist_full) begin
        hist_count <= hist_count + CNT_W'(1);
      end
      priority if (integ_acc > (INTEG_W+1)'(integ_max)) begin
        error_sum <= integ_max;
      end else if (integ_acc < (INTEG_W+1)'(integ_min)) begin
        error_sum <= integ_min;
      end else begin
        error_sum <= INTEG_W'(integ_acc);
      end
    end
  end

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_hist
    if (k == HISTORY_DEPTH - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (state == S_HIST && (hist_full || hist_count[IDX_W-1:0] == IDX_W'(k))) begin
          hist[k] <= delta;
        end
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (state == S_HIST) begin
          if (hist_full) begin
            hist[k] <= hist[k+1];
          end else if (hist_count[IDX_W-1:0] == IDX_W'(k)) begin
            hist[k] <= delta;
          end
        end
      end
    end
  end

  // one held difference per cycle
  assign sum_last = (CNT_W'(sum_idx) == CNT_W'(hist_count - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (state == S_HIST) begin
      sum_acc <= '0;
      sum_idx <= '0;
    end else if (state == S_SUM) begin
      sum_acc <= sum_acc + SUM_W'(hist[sum_idx]);
      sum_idx <= sum_idx + IDX_W'(1);
    end
    if (state == S_DIV && div_done) begin
      mean <= quotient;
    end
  end

  yap_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (hist_count),
    .done     (div_done),
    .quotient (quotient)
  );

  // ---------------------------------------------------------- gain terms
  yap_mul #(.A_W(ERR_W)) u_mul_p (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (err),
    .b       (prop_gain),
    .done    (p_done),
    .product (p_prod)
  );

  yap_mul #(.A_W(INTEG_W)) u_mul_i (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (error_sum),
    .b       (integ_gain),
    .done    (i_done),
    .product (i_prod)
  );

  yap_mul #(.A_W(SUM_W)) u_mul_d (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mean),
    .b       (deriv_gain),
    .done    (d_done),
    .product (d_prod)
  );

  assign p_sh    = p_prod[ERR_W+GAIN_W-1:FRAC_W];
  assign lim_pos = $signed({1'b0, drive_limit});
  assign lim_neg = -lim_pos;

  always_ff @(posedge clk) begin
    if (state == S_TERM) begin
      priority if (p_sh > (ERR_W+GAIN_W-FRAC_W)'(lim_pos)) begin
        p_term <= lim_pos;
      end else if (p_sh < (ERR_W+GAIN_W-FRAC_W)'(lim_neg)) begin
        p_term <= lim_neg;
      end else begin
        p_term <= DRIVE_W'(p_sh);
      end
      id_sum <= TOTAL_W'($signed(i_prod[INTEG_W+GAIN_W-1:FRAC_W]))
              + TOTAL_W'($signed(d_prod[SUM_W+GAIN_W-1:FRAC_W]));
    end
    if (state == S_TOTAL) begin
      total <= id_sum + TOTAL_W'(p_term);
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      heading_error_q <= err;
      priority if (total > TOTAL_W'(lim_pos)) begin
        drive_q <= lim_pos;
      end else if (total < TOTAL_W'(lim_neg)) begin
        drive_q <= lim_neg;
      end else begin
        drive_q <= DRIVE_W'(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (command.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign command.valid         = out_valid;
  assign command.drive         = drive_q;
  assign command.heading_error = heading_error_q;

  // ----------------------------------------------------------- checks
  `YAP_ASSERT_IMP(a_mul_in_step, clk, rst, p_done, i_done && d_done && state == S_MUL)
  `YAP_ASSERT_IMP(a_div_in_state, clk, rst, div_done, state == S_DIV)
  `YAP_ASSERT_IMP(a_sum_has_entries, clk, rst, state == S_SUM, hist_count != '0)
  `YAP_ASSERT_NXT(a_hist_to_sum, clk, rst, state == S_HIST, state == S_SUM)
  `YAP_ASSERT_IMP(a_load_free, clk, rst, out_load, !out_valid || command.ready)

endmodule

// ===== verif/yaw_angle_pid_tb.sv =====
// ----------------------------------------------------------------------------
// yaw_angle_pid_tb
// Self-checking bench for the heading PID. A scoreboard class predicts each
// command beat (wrapped heading error and clamped drive) from the sampled
// heading and the tuning registers. The bench opens with directed wrap,
// saturation, clamp, inverted-bound and unused-index cases, then runs random tuning sets with random
// headings under changing valid/ready idling and one long command stall.
// ----------------------------------------------------------------------------
module yaw_angle_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import yap_pkg::*;

  localparam int                   SETTLE_CYCLES  = 64;
  localparam int                   WATCHDOG_LIMIT = 5000;
  localparam int                   STALL_CYCLES   = 400;
  localparam int                   SETS_PER_MODE  = 4;
  localparam int                   ITEMS_PER_SET  = 90;
  localparam logic [REG_IDX_W-1:0] REG_NONE       = 3'd7;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   heading_error;
  } command_t;

  class heading_pid_scoreboard;
    logic signed [ANGLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
    logic        [LIMIT_W-1:0] drive_cap;
    logic signed [INTEG_W-1:0] sum_ceiling;
    logic signed [INTEG_W-1:0] sum_floor;
    logic signed [INTEG_W-1:0] error_sum;
    logic signed [ERR_W-1:0]   prior_error;
    logic signed [DELTA_W-1:0] deltas [HISTORY_DEPTH_DEF];
    int unsigned               n_deltas;
    command_t                  expected_commands [$];
    int                        mismatches;
    int                        samples_seen;
    int                        commands_seen;

    function new();
      setpoint      = '0;
      kp            = '0;
      ki            = '0;
      kd            = '0;
      drive_cap     = DRIVE_LIMIT_RST;
      sum_ceiling   = INTEG_MAX_RST;
      sum_floor     = INTEG_MIN_RST;
      error_sum     = '0;
      mismatches    = 0;
      samples_seen  = 0;
      commands_seen = 0;
      clear_history();
    endfunction

    function void clear_history();
      foreach (deltas[k]) deltas[k] = '0;
      n_deltas    = 0;
      prior_error = '0;
    endfunction

    function longint clamp_sym(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_ANGLE: begin
          setpoint = data[ANGLE_W-1:0];
          clear_history();
        end
        REG_PROP_GAIN:   kp          = data[GAIN_W-1:0];
        REG_INTEG_GAIN:  ki          = data[GAIN_W-1:0];
        REG_DERIV_GAIN:  kd          = data[GAIN_W-1:0];
        REG_DRIVE_LIMIT: drive_cap   = data[LIMIT_W-1:0];
        REG_INTEG_MAX:   sum_ceiling = data[INTEG_W-1:0];
        REG_INTEG_MIN:   sum_floor   = data[INTEG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(angle_t heading);
      longint   angle, err, acc, sum, mean, p_term, i_term, d_term, cap;
      int       k;
      command_t cmd;
      angle = heading;
      cap   = drive_cap;
      err   = setpoint - angle;
      if (err > HALF_TURN || err < -HALF_TURN) begin
        angle = (angle > 0) ? angle - FULL_TURN : angle + FULL_TURN;
        err   = setpoint - angle;
      end
      err = clamp_sym(err, ERR_LIMIT);

      if (n_deltas >= HISTORY_DEPTH_DEF) begin
        for (k = 1; k < HISTORY_DEPTH_DEF; k++) deltas[k-1] = deltas[k];
        deltas[HISTORY_DEPTH_DEF-1] = err - prior_error;
      end else begin
        deltas[n_deltas] = err - prior_error;
        n_deltas++;
      end
      sum = 0;
      for (k = 0; k < n_deltas; k++) sum += deltas[k];
      mean = sum / longint'(n_deltas);

      // upper bound is checked first: with inverted bounds a sum above it takes it, any other the lower
      acc = error_sum + err;
      if (acc > sum_ceiling) acc = sum_ceiling;
      else if (acc < sum_floor) acc = sum_floor;
      error_sum = acc;

      p_term = clamp_sym((kp * err) >>> FRAC_W, cap);
      i_term = (longint'(error_sum) * ki) >>> FRAC_W;
      d_term = (kd * mean) >>> FRAC_W;
      prior_error = err;

      cmd.drive         = clamp_sym(p_term + i_term + d_term, cap);
      cmd.heading_error = err;
      expected_commands.insert(expected_commands.size(), cmd);
      samples_seen++;
    endfunction

    function void check_command(logic signed [DRIVE_W-1:0] drive,
                                logic signed [ERR_W-1:0] heading_error);
      command_t want;
      commands_seen++;
      if (expected_commands.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected command beat: drive %0d, heading_error %0d",
                 $time, drive, heading_error);
        return;
      end
      want = expected_commands.pop_front();
      if (drive !== want.drive) begin
        mismatches++;
        $display("%0t: drive mismatch: expected %0d, actual %0d",
                 $time, $signed(want.drive), drive);
      end
      if (heading_error !== want.heading_error) begin
        mismatches++;
        $display("%0t: heading_error mismatch: expected %0d, actual %0d",
                 $time, $signed(want.heading_error), heading_error);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [REG_DATA_W-1:0] wr_data;

  yap_in_if  smp_if ();
  yap_out_if cmd_if ();

  yaw_angle_pid u_top (
    .clk      (clk),
    .rst      (rst),
    .sample   (smp_if),
    .command  (cmd_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  heading_pid_scoreboard pid_sb = new();

  int source_idle_pct = 0;
  int sink_idle_pct   = 0;
  bit stall_request   = 1'b0;
  int stall_left      = 0;
  int quiet_cycles    = 0;
  int walk_angle      = 0;
  int tuning_sets     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // command receiver: random backpressure plus one long hold-off on request
  initial begin
    cmd_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready)
        pid_sb.check_command(cmd_if.drive, cmd_if.heading_error);
      if ((cmd_if.valid && cmd_if.ready) || (smp_if.valid && smp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(input angle_t heading);
    while ($urandom_range(99) < source_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid          <= 1'b1;
    smp_if.measured_angle <= heading;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    pid_sb.note_sample(heading);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= REG_DATA_W'(value);
    @(posedge clk);
    pid_sb.write_register(idx, REG_DATA_W'(value));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_commands();
    smp_if.valid <= 1'b0;
    while (pid_sb.expected_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_signed(int w, int typical);
    int r;
    case ($urandom_range(7))
      0:       r = -(1 <<< (w-1));
      1:       r = (1 <<< (w-1)) - 1;
      2, 3:    r = (int'($urandom) <<< (32-w)) >>> (32-w);
      default: r = int'($urandom_range(2*typical)) - typical;
    endcase
    return r;
  endfunction

  function automatic angle_t next_angle();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      walk_angle += int'($urandom_range(600)) - 300;
      if (walk_angle > 11520) walk_angle -= 23040;
      else if (walk_angle < -11520) walk_angle += 23040;
    end else if (pick < 85) begin
      walk_angle = int'($urandom_range(23040)) - 11520;
    end else begin
      walk_angle = int'($urandom_range(32767)) - 16384;
    end
    return angle_t'(walk_angle);
  endfunction

  task automatic load_random_tuning();
    int hi, lo, swap, cap;
    hi = pick_signed(INTEG_W, 150000);
    lo = pick_signed(INTEG_W, 150000);
    if (hi < lo && $urandom_range(4) != 0) begin
      swap = hi;
      hi   = lo;
      lo   = swap;
    end
    case ($urandom_range(7))
      0:       cap = 0;
      1:       cap = int'(DRIVE_LIMIT_RST);
      2:       cap = $urandom_range(int'(DRIVE_LIMIT_RST));
      default: cap = $urandom_range(60000);
    endcase
    write_reg(REG_TARGET_ANGLE, pick_signed(ANGLE_W, 11520));
    write_reg(REG_PROP_GAIN, pick_signed(GAIN_W, 700));
    write_reg(REG_INTEG_GAIN, pick_signed(GAIN_W, 64));
    write_reg(REG_DERIV_GAIN, pick_signed(GAIN_W, 700));
    write_reg(REG_DRIVE_LIMIT, cap);
    write_reg(REG_INTEG_MAX, hi);
    write_reg(REG_INTEG_MIN, lo);
    if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom);
    tuning_sets++;
  endtask

  initial begin
    rst                   <= 1'b1;
    wr_en                 <= 1'b0;
    wr_index              <= '0;
    wr_data               <= '0;
    smp_if.valid          <= 1'b0;
    smp_if.measured_angle <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    source_idle_pct = 25;
    sink_idle_pct   = 87;

    // reset tuning: zero gains give zero drive
    send_sample(15'sd0);
    wait_for_commands();

    // wrap boundaries around a zero setpoint
    write_reg(REG_PROP_GAIN, 256);
    write_reg(REG_INTEG_GAIN, 64);
    write_reg(REG_DERIV_GAIN, 512);
    send_sample(15'sd11520);
    send_sample(-15'sd11520);
    send_sample(15'sd11521);
    send_sample(-15'sd11521);
    send_sample(15'sd0);
    send_sample(15'sd16383);
    send_sample(-15'sd16384);
    wait_for_commands();

    // setpoint at the field extremes: saturated error and wrap of angle zero
    write_reg(REG_TARGET_ANGLE, 16383);
    send_sample(15'sd1);
    send_sample(15'sd0);
    send_sample(-15'sd16384);
    wait_for_commands();
    write_reg(REG_TARGET_ANGLE, -16384);
    send_sample(-15'sd1);
    send_sample(15'sd16383);
    wait_for_commands();

    // extreme gains against a small drive clamp
    write_reg(REG_TARGET_ANGLE, 0);
    write_reg(REG_PROP_GAIN, 32767);
    write_reg(REG_INTEG_GAIN, -32768);
    write_reg(REG_DERIV_GAIN, -32768);
    write_reg(REG_DRIVE_LIMIT, 1000);
    send_sample(15'sd11520);
    send_sample(-15'sd11520);
    send_sample(15'sd100);
    wait_for_commands();
    write_reg(REG_DRIVE_LIMIT, 0);
    send_sample(15'sd500);
    wait_for_commands();

    // inverted integrator bounds
    write_reg(REG_DRIVE_LIMIT, int'(DRIVE_LIMIT_RST));
    write_reg(REG_PROP_GAIN, -32768);
    write_reg(REG_INTEG_GAIN, 32767);
    write_reg(REG_DERIV_GAIN, 32767);
    write_reg(REG_INTEG_MAX, -100);
    write_reg(REG_INTEG_MIN, 100);
    send_sample(15'sd50);
    send_sample(-15'sd50);
    send_sample(15'sd300);
    wait_for_commands();

    // write to an unused index changes nothing
    write_reg(REG_NONE, 24'hFFFFFF);
    send_sample(15'sd200);
    wait_for_commands();

    for (int set_idx = 0; set_idx < 3 * SETS_PER_MODE; set_idx++) begin
      if (set_idx == SETS_PER_MODE) begin
        source_idle_pct = 87;
        sink_idle_pct   = 25;
      end else if (set_idx == 2 * SETS_PER_MODE) begin
        source_idle_pct = 0;
        sink_idle_pct   = 0;
      end
      load_random_tuning();
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        if (k == ITEMS_PER_SET / 2 && set_idx % SETS_PER_MODE == 1) wait_for_commands();
        send_sample(next_angle());
      end
      wait_for_commands();
    end

    // long command stall while samples keep coming
    load_random_tuning();
    stall_request = 1'b1;
    for (int k = 0; k < 30; k++) send_sample(next_angle());
    wait_for_commands();

    $display("Checked %0d command beats from %0d heading samples over %0d tuning sets,",
             pid_sb.commands_seen, pid_sb.samples_seen, tuning_sets);
    $display("with wrap, error saturation, clamp and backpressure cases; %0d mismatches.",
             pid_sb.mismatches);
    if (pid_sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
